### hdl/dpr_pkg.sv
// shared types, codes and constants of the dsss plcp bit receiver
`timescale 1ns / 1ps
package dpr_pkg;

  localparam logic [15:0] SYNC_LONG  = 16'h05CF;
  localparam logic [15:0] SYNC_SHORT = 16'hF3A0;
  localparam logic [6:0]  SEED_LONG  = 7'h1B;
  localparam logic [6:0]  SEED_SHORT = 7'h6C;
  localparam logic [15:0] CRC_TAPS   = 16'h0810;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [7:0]  SIG_1M     = 8'h0A;
  localparam logic [7:0]  SIG_2M     = 8'h14;
  localparam logic [7:0]  SIG_5M5    = 8'h37;
  localparam logic [7:0]  SIG_11M    = 8'h6E;
  localparam logic [5:0]  CRC_START  = 6'd32;
  localparam logic [5:0]  HDR_BITS   = 6'd48;

  localparam logic [1:0] RATE_1M  = 2'd0;
  localparam logic [1:0] RATE_2M  = 2'd1;
  localparam logic [1:0] RATE_5M5 = 2'd2;
  localparam logic [1:0] RATE_11M = 2'd3;

  typedef enum logic [1:0] {
    KIND_HDR_OK  = 2'd0,
    KIND_HDR_BAD = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] sym_bits;
    logic       lost;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  rate_code;
    logic [7:0]  service_field;
    logic [16:0] byte_count;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  // one bit of the header crc, msb feedback, shift left
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
    logic        fb;
    logic [15:0] c;
    fb = crc[15] ^ b;
    c  = fb ? (crc ^ CRC_TAPS) : crc;
    return {c[14:0], fb};
  endfunction

endpackage

### hdl/dpr_in_reg.sv
// input register with valid/stall handshake
`timescale 1ns / 1ps
module dpr_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     sym_bits,
  input  logic           lost,
  input  logic           take,
  output logic           item_valid,
  output dpr_pkg::item_t item
);
  import dpr_pkg::*;

  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.sym_bits <= sym_bits;
      item.lost     <= lost;
    end
  end

endmodule

### hdl/dpr_core.sv
// receiver state: sync search, header gather and check, psdu packing, result register
`timescale 1ns / 1ps
module dpr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             item_valid,
  input  dpr_pkg::item_t   item,
  output logic             take,
  output logic             res_valid,
  input  logic             res_stall,
  output dpr_pkg::result_t res
);
  import dpr_pkg::*;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_PSDU   = 2'd2
  } mode_t;

  mode_t       mode, mode_next;
  logic        short_pre;
  logic [6:0]  scrambler, scrambler_next;
  logic [15:0] sync_shift, sync_shift_next;
  logic [31:0] header_shift, header_shift_next;
  logic [15:0] crc_rx, crc_rx_next;
  logic [15:0] crc_run, crc_run_next;
  logic [5:0]  hdr_count, hdr_count_next;
  logic [1:0]  psdu_rate, psdu_rate_next;
  logic [16:0] bytes_left, bytes_left_next;
  logic [7:0]  byte_accum, byte_accum_next;
  logic [2:0]  bit_offset, bit_offset_next;
  logic [3:0]  off;
  logic [3:0]  nbits;
  logic        d;
  logic        fire;
  result_t     res_next;
  logic [6:0]  seed;
  logic [15:0] sync_word;
  logic [19:0] len_x11;
  logic [16:0] count;
  logic        hdr_ok;

  assign take      = item_valid && (!res_valid || !res_stall);
  assign seed      = short_pre ? SEED_SHORT : SEED_LONG;
  assign sync_word = short_pre ? SYNC_SHORT : SYNC_LONG;

  always_comb begin
    mode_next         = mode;
    scrambler_next    = scrambler;
    sync_shift_next   = sync_shift;
    header_shift_next = header_shift;
    crc_rx_next       = crc_rx;
    crc_run_next      = crc_run;
    hdr_count_next    = hdr_count;
    psdu_rate_next    = psdu_rate;
    bytes_left_next   = bytes_left;
    byte_accum_next   = byte_accum;
    bit_offset_next   = bit_offset;
    fire              = 1'b0;
    res_next          = '0;
    off               = {1'b0, bit_offset};
    nbits             = 4'd1 << psdu_rate;
    d                 = 1'b0;
    count             = '0;
    hdr_ok            = 1'b0;
    len_x11           = '0;

    case (mode)
      MODE_HEADER, MODE_PSDU: begin
        if (item.lost) begin
          fire           = 1'b1;
          res_next.kind  = KIND_ABORT;
          mode_next      = MODE_SEARCH;
          scrambler_next = seed;
        end else if (mode == MODE_HEADER) begin
          for (int i = 0; i < 2; i++) begin
            if (i == 0 || short_pre) begin
              d              = item.sym_bits[i] ^ scrambler_next[3] ^ scrambler_next[6];
              scrambler_next = {scrambler_next[5:0], item.sym_bits[i]};
              if (hdr_count_next < CRC_START) begin
                header_shift_next[hdr_count_next[4:0]] = d;
                crc_run_next = crc_step(crc_run_next, d);
              end else if (hdr_count_next < HDR_BITS) begin
                crc_rx_next[hdr_count_next[3:0]] = d;
              end
              hdr_count_next = hdr_count_next + 6'd1;
            end
          end
          if (hdr_count_next >= HDR_BITS) begin
            hdr_count_next = '0;
            fire           = 1'b1;
            len_x11        = {4'd0, header_shift_next[31:16]} * 20'd11;
            if ((crc_run_next ^ crc_rx_next) == 16'hFFFF) begin
              case (header_shift_next[7:0])
                SIG_1M: begin
                  hdr_ok             = !short_pre;
                  res_next.rate_code = RATE_1M;
                  count              = {4'd0, header_shift_next[31:19]};
                end
                SIG_2M: begin
                  hdr_ok             = 1'b1;
                  res_next.rate_code = RATE_2M;
                  count              = {3'd0, header_shift_next[31:18]};
                end
                SIG_5M5: begin
                  hdr_ok             = 1'b1;
                  res_next.rate_code = RATE_5M5;
                  count              = {1'b0, len_x11[19:4]};
                end
                SIG_11M: begin
                  hdr_ok             = 1'b1;
                  res_next.rate_code = RATE_11M;
                  count              = len_x11[19:3];
                  // length extension bit trims one byte
                  if (header_shift_next[15] && count != '0) begin
                    count = count - 17'd1;
                  end
                end
                default: begin
                  hdr_ok = 1'b0;
                end
              endcase
            end
            if (hdr_ok) begin
              res_next.kind          = KIND_HDR_OK;
              res_next.service_field = header_shift_next[15:8];
              res_next.byte_count    = count;
              psdu_rate_next         = res_next.rate_code;
              bytes_left_next        = count;
              byte_accum_next        = '0;
              bit_offset_next        = '0;
              if (count == '0) begin
                mode_next      = MODE_SEARCH;
                scrambler_next = seed;
              end else begin
                mode_next = MODE_PSDU;
              end
            end else begin
              res_next       = '0;
              res_next.kind  = KIND_HDR_BAD;
              mode_next      = MODE_SEARCH;
              scrambler_next = seed;
            end
          end
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (4'(i) < nbits) begin
              d              = item.sym_bits[i] ^ scrambler_next[3] ^ scrambler_next[6];
              scrambler_next = {scrambler_next[5:0], item.sym_bits[i]};
              if (!off[3]) begin
                byte_accum_next[off[2:0]] = d;
              end
              off = off + 4'd1;
            end
          end
          if (off[3]) begin
            fire               = 1'b1;
            res_next.kind      = KIND_DATA;
            res_next.data_byte = byte_accum_next;
            byte_accum_next    = '0;
            bit_offset_next    = '0;
            if (bytes_left != '0) begin
              bytes_left_next = bytes_left - 17'd1;
            end
            if (bytes_left_next == '0) begin
              res_next.last  = 1'b1;
              mode_next      = MODE_SEARCH;
              scrambler_next = seed;
            end
          end else begin
            bit_offset_next = off[2:0];
          end
        end
      end
      default: begin
        mode_next = MODE_SEARCH;
        if (!item.lost) begin
          d               = item.sym_bits[0] ^ scrambler[3] ^ scrambler[6];
          scrambler_next  = {scrambler[5:0], item.sym_bits[0]};
          sync_shift_next = {sync_shift[14:0], d};
          if (sync_shift_next == sync_word) begin
            mode_next         = MODE_HEADER;
            header_shift_next = '0;
            crc_rx_next       = '0;
            crc_run_next      = CRC_PRESET;
            hdr_count_next    = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SEARCH;
      short_pre    <= 1'b0;
      scrambler    <= SEED_LONG;
      sync_shift   <= '0;
      header_shift <= '0;
      crc_rx       <= '0;
      crc_run      <= CRC_PRESET;
      hdr_count    <= '0;
      psdu_rate    <= '0;
      bytes_left   <= '0;
      byte_accum   <= '0;
      bit_offset   <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en && (cfg_wr_data != short_pre)) begin
        // preamble change restarts the search with the new seed
        short_pre <= cfg_wr_data;
        mode      <= MODE_SEARCH;
        scrambler <= cfg_wr_data ? SEED_SHORT : SEED_LONG;
      end else if (take) begin
        mode         <= mode_next;
        scrambler    <= scrambler_next;
        sync_shift   <= sync_shift_next;
        header_shift <= header_shift_next;
        crc_rx       <= crc_rx_next;
        crc_run      <= crc_run_next;
        hdr_count    <= hdr_count_next;
        psdu_rate    <= psdu_rate_next;
        bytes_left   <= bytes_left_next;
        byte_accum   <= byte_accum_next;
        bit_offset   <= bit_offset_next;
      end
      if (take) begin
        res_valid <= fire;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) begin
      res <= res_next;
    end
  end

endmodule

### hdl/dsss_plcp_bit_receiver.sv
// top level of the dsss plcp bit receiver
`timescale 1ns / 1ps
// Takes one demodulated symbol beat per clock and returns zero or one result
// beat for it: header accepted, header rejected, a descrambled data byte, or
// an abort on a lost symbol. A symbol is registered on accept in the input
// register, the whole state update for it (descrambler, sync compare, header
// crc and length decode with one 16x4 multiply, byte packing) runs when the
// core takes it, and its result lands in the output register; one symbol is
// taken every cycle as long as the output side keeps up. The output register
// holds while out_stall is high; a new symbol is still registered then if the
// input register is empty, and waits. There is no clearing pass after reset.
// Write cfg_wr_en/cfg_wr_data only while the block is idle; changing the
// preamble restarts the sync search.
module dsss_plcp_bit_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  sym_bits,
  input  logic        lost,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  rate_code,
  output logic [7:0]  service_field,
  output logic [16:0] byte_count,
  output logic [7:0]  data_byte,
  output logic        last
);
  import dpr_pkg::*;

  logic    take;
  logic    item_valid;
  item_t   item;
  result_t res;

  dpr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sym_bits   (sym_bits),
    .lost       (lost),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dpr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .take        (take),
    .res_valid   (out_valid),
    .res_stall   (out_stall),
    .res         (res)
  );

  assign kind          = res.kind;
  assign rate_code     = res.rate_code;
  assign service_field = res.service_field;
  assign byte_count    = res.byte_count;
  assign data_byte     = res.data_byte;
  assign last          = res.last;

endmodule

### hdl/dpr_checker.sv
// port-level checks of the dsss plcp bit receiver, bound to the top level
`timescale 1ns / 1ps
module dpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  sym_bits,
  input logic        lost,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [1:0]  rate_code,
  input logic [7:0]  service_field,
  input logic [16:0] byte_count,
  input logic [7:0]  data_byte,
  input logic        last
);
  import dpr_pkg::*;

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result beat stays and holds its kind and byte
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte))
    else $error("stalled result beat changed");

  // header fields only on an accepted header
  a_hdr_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_HDR_OK |->
      rate_code == 2'd0 && service_field == 8'd0 && byte_count == 17'd0)
    else $error("header fields set outside accepted header");

  // data fields only on a data beat
  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0 && !last)
    else $error("data fields set outside data beat");

  // a stalled symbol beat stays and holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(sym_bits) && $stable(lost))
    else $error("stalled symbol beat changed");

endmodule

bind dsss_plcp_bit_receiver dpr_checker u_dpr_checker (.*);
